@@ src/ffbt_pkg.sv @@
package ffbt_pkg;

  localparam int unsigned GranW    = 12;
  localparam int unsigned UserGW   = 13;
  localparam int unsigned HeapW    = 17;
  localparam int unsigned AddrW    = 16;
  localparam int unsigned GranShift = 4;

  localparam logic [UserGW-1:0] HdrG  = 13'd2;
  localparam logic [UserGW-1:0] TagG  = 13'd1;
  localparam logic [UserGW-1:0] MetaG = 13'd3;
  localparam logic [UserGW-1:0] SplitMin = 13'd4;
  localparam logic [HeapW-1:0]  GranBytes = 17'd16;
  localparam logic [HeapW:0]    HeapMaxBytes = 18'd65536;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OOM   = 2'd1,
    ST_DFREE = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [AddrW-1:0]  request_bytes;
    logic [AddrW-1:0]  user_address;
  } ffbt_req_t;

  typedef struct packed {
    logic [AddrW-1:0]  result_address;
    status_e           status;
  } ffbt_rsp_t;

  typedef struct packed {
    logic              is_free;
    logic [GranW-1:0]  prev;
    logic [GranW-1:0]  nxt;
    logic [GranW-1:0]  size;
  } hdr_t;

  function automatic logic [GranW-1:0] tag_idx(input logic [13:0] a);
    return (a[13:12] != 2'b00) ? '0 : a[11:0];
  endfunction

  function automatic logic [AddrW-1:0] user_addr(input logic [GranW-1:0] b);
    logic [16:0] t;
    t = {({1'b0, b} + 13'd2), 4'b0000};
    return t[AddrW-1:0];
  endfunction

endpackage

@@ src/first_fit_boundary_tag_allocator.sv @@
// Sequence from input accept to out_valid_o: a null or malformed free goes straight to the
//   result. A free walks the heap block by block, then the free list for the insert, then
//   does the list updates and both merges.
// Allocate: scans the free list entry by entry, then unlinks the fit and may split it (plus the
//   insert walk of a split remainder), or doubles the heap until its end can be extended.
// Throughput: one item at a time; in_ready_o stays low until the result beat is posted.
// Reset: free list empty, heap not yet claimed; the stores are not cleared.
module first_fit_boundary_tag_allocator
  import ffbt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [HeapW-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ffbt_req_t        in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ffbt_rsp_t        out_data_o
);

  localparam logic [5:0] S_IDLE       = 6'd0;
  localparam logic [5:0] S_WALK_RD    = 6'd1;
  localparam logic [5:0] S_WALK_CHK   = 6'd2;
  localparam logic [5:0] S_INS        = 6'd3;
  localparam logic [5:0] S_INS_HP_WR  = 6'd4;
  localparam logic [5:0] S_INS_WK_RD  = 6'd5;
  localparam logic [5:0] S_INS_WK_CHK = 6'd6;
  localparam logic [5:0] S_INS_NX_WR  = 6'd7;
  localparam logic [5:0] S_INS_CUR_WR = 6'd8;
  localparam logic [5:0] S_REM        = 6'd9;
  localparam logic [5:0] S_REM_CHK    = 6'd10;
  localparam logic [5:0] S_REM_PV_WR  = 6'd11;
  localparam logic [5:0] S_REM_NX     = 6'd12;
  localparam logic [5:0] S_REM_NX_WR  = 6'd13;
  localparam logic [5:0] S_REM_X_WR   = 6'd14;
  localparam logic [5:0] S_MG_RD2     = 6'd15;
  localparam logic [5:0] S_MG_RD1     = 6'd16;
  localparam logic [5:0] S_MG_WR1     = 6'd17;
  localparam logic [5:0] S_MG_TAG     = 6'd18;
  localparam logic [5:0] S_FR_NX_RD   = 6'd19;
  localparam logic [5:0] S_FR_NX_CHK  = 6'd20;
  localparam logic [5:0] S_FR_NX_CHK2 = 6'd21;
  localparam logic [5:0] S_FR_PV      = 6'd22;
  localparam logic [5:0] S_FR_PV_CHK  = 6'd23;
  localparam logic [5:0] S_FR_PV_CHK2 = 6'd24;
  localparam logic [5:0] S_FIT_RD     = 6'd25;
  localparam logic [5:0] S_FIT_CHK    = 6'd26;
  localparam logic [5:0] S_AL_SPLIT   = 6'd27;
  localparam logic [5:0] S_AL_SPLIT2  = 6'd28;
  localparam logic [5:0] S_GROW       = 6'd29;
  localparam logic [5:0] S_DONE       = 6'd30;

  localparam int unsigned Depth = 1 << GranW;

  hdr_t             hdr_mem [Depth];
  logic [GranW-1:0] tag_mem [Depth];

  logic [5:0]        state_q, state_d, sub_ret_q, sub_ret_d, mrg_ret_q, mrg_ret_d;
  logic [UserGW-1:0] user_g_q, user_g_d;
  logic [GranW-1:0]  b_q, b_d, cur_q, cur_d, x_q, x_d, xsize_q, xsize_d;
  logic [GranW-1:0]  m1_q, m1_d, m2_q, m2_d, msz_q, msz_d, fsz_q, fsz_d;
  logic [13:0]       g_q, g_d;
  hdr_t              h_q, h_d;
  logic [UserGW-1:0] head_q, head_d, end_g_q, end_g_d;
  logic [HeapW-1:0]  heap_q, heap_d, init_q;
  logic              started_q, started_d;
  ffbt_rsp_t         res_q, res_d, out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic [GranW-1:0] hdr_ra, hdr_wa, tag_ra, tag_wa, tag_wd;
  logic             hdr_we, tag_we;
  hdr_t             hdr_wd, hdr_rd_q, hw;
  logic [GranW-1:0] tag_rd_q;

  logic [13:0]       sum14, nx14;
  logic [UserGW-1:0] left;
  logic [GranW-1:0]  lsz, spos;
  logic [HeapW-1:0]  init_v;

  always_ff @(posedge clk_i) begin
    hdr_rd_q <= hdr_mem[hdr_ra];
    if (hdr_we) begin
      hdr_mem[hdr_wa] <= hdr_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_rd_q <= tag_mem[tag_ra];
    if (tag_we) begin
      tag_mem[tag_wa] <= tag_wd;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    if (init_q < GranBytes) begin
      init_v = GranBytes;
    end else if ({1'b0, init_q} > HeapMaxBytes) begin
      init_v = HeapMaxBytes[HeapW-1:0];
    end else begin
      init_v = init_q;
    end
  end

  always_comb begin
    state_d     = state_q;
    sub_ret_d   = sub_ret_q;
    mrg_ret_d   = mrg_ret_q;
    user_g_d    = user_g_q;
    b_d         = b_q;
    cur_d       = cur_q;
    x_d         = x_q;
    xsize_d     = xsize_q;
    m1_d        = m1_q;
    m2_d        = m2_q;
    msz_d       = msz_q;
    fsz_d       = fsz_q;
    g_d         = g_q;
    h_d         = h_q;
    head_d      = head_q;
    end_g_d     = end_g_q;
    heap_d      = heap_q;
    started_d   = started_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    hdr_ra      = '0;
    hdr_we      = 1'b0;
    hdr_wa      = '0;
    hdr_wd      = '0;
    tag_ra      = '0;
    tag_we      = 1'b0;
    tag_wa      = '0;
    tag_wd      = '0;
    hw          = hdr_rd_q;
    sum14       = {1'b0, end_g_q} + {1'b0, user_g_q} + {1'b0, MetaG};
    nx14        = {2'b00, b_q} + {2'b00, hdr_rd_q.size} + {1'b0, MetaG};
    left        = {1'b0, fsz_q} - user_g_q;
    lsz         = fsz_q - user_g_q[GranW-1:0] - MetaG[GranW-1:0];
    spos        = b_q + user_g_q[GranW-1:0] + MetaG[GranW-1:0];

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_d.result_address = '0;
          res_d.status         = ST_OK;
          if (in_data_i.cmd == CMD_FREE) begin
            if (in_data_i.user_address == '0) begin
              state_d = S_DONE;
            end else if (in_data_i.user_address[3:0] != 4'd0 ||
                         in_data_i.user_address[15:4] < HdrG[GranW-1:0]) begin
              res_d.status = ST_DFREE;
              state_d      = S_DONE;
            end else begin
              b_d     = in_data_i.user_address[15:4] - HdrG[GranW-1:0];
              g_d     = '0;
              state_d = S_WALK_RD;
            end
          end else begin
            if (!started_q) begin
              started_d = 1'b1;
              end_g_d   = '0;
              heap_d    = init_v;
            end
            user_g_d = UserGW'(({1'b0, in_data_i.request_bytes} + 17'd15) >> GranShift);
            if (head_q == '0) begin
              state_d = S_GROW;
            end else begin
              cur_d   = head_q[GranW-1:0] - 12'd1;
              state_d = S_FIT_RD;
            end
          end
        end
      end

      S_WALK_RD: begin
        if (g_q >= {1'b0, end_g_q} || g_q > {2'b00, b_q}) begin
          res_d.status = ST_DFREE;
          state_d      = S_DONE;
        end else begin
          hdr_ra  = g_q[GranW-1:0];
          state_d = S_WALK_CHK;
        end
      end

      S_WALK_CHK: begin
        if (g_q == {2'b00, b_q}) begin
          if (hdr_rd_q.is_free) begin
            res_d.status = ST_DFREE;
            state_d      = S_DONE;
          end else begin
            x_d       = b_q;
            xsize_d   = hdr_rd_q.size;
            sub_ret_d = S_FR_NX_RD;
            state_d   = S_INS;
          end
        end else begin
          g_d     = g_q + {2'b00, hdr_rd_q.size} + {1'b0, MetaG};
          state_d = S_WALK_RD;
        end
      end

      S_INS: begin
        hdr_ra = head_q[GranW-1:0] - 12'd1;
        if (head_q == '0) begin
          hdr_we = 1'b1;
          hdr_wa = x_q;
          hdr_wd = '{is_free: 1'b1, prev: '0, nxt: '0, size: xsize_q};
          head_d = {1'b0, x_q} + 13'd1;
          state_d = sub_ret_q;
        end else if ({1'b0, x_q} < head_q - 13'd1) begin
          hdr_we  = 1'b1;
          hdr_wa  = x_q;
          hdr_wd  = '{is_free: 1'b1, prev: '0, nxt: head_q[GranW-1:0] - 12'd1,
                      size: xsize_q};
          cur_d   = head_q[GranW-1:0] - 12'd1;
          head_d  = {1'b0, x_q} + 13'd1;
          state_d = S_INS_HP_WR;
        end else begin
          cur_d   = head_q[GranW-1:0] - 12'd1;
          state_d = S_INS_WK_RD;
        end
      end

      S_INS_HP_WR: begin
        hw.prev = x_q;
        hdr_we  = 1'b1;
        hdr_wa  = cur_q;
        hdr_wd  = hw;
        state_d = sub_ret_q;
      end

      S_INS_WK_RD: begin
        hdr_ra  = cur_q;
        state_d = S_INS_WK_CHK;
      end

      S_INS_WK_CHK: begin
        if (hdr_rd_q.nxt == '0 || hdr_rd_q.nxt > x_q) begin
          h_d    = hdr_rd_q;
          hdr_we = 1'b1;
          hdr_wa = x_q;
          hdr_wd = '{is_free: 1'b1, prev: cur_q, nxt: hdr_rd_q.nxt, size: xsize_q};
          if (hdr_rd_q.nxt != '0) begin
            hdr_ra  = hdr_rd_q.nxt;
            state_d = S_INS_NX_WR;
          end else begin
            state_d = S_INS_CUR_WR;
          end
        end else begin
          cur_d   = hdr_rd_q.nxt;
          state_d = S_INS_WK_RD;
        end
      end

      S_INS_NX_WR: begin
        hw.prev = x_q;
        hdr_we  = 1'b1;
        hdr_wa  = h_q.nxt;
        hdr_wd  = hw;
        state_d = S_INS_CUR_WR;
      end

      S_INS_CUR_WR: begin
        hdr_we     = 1'b1;
        hdr_wa     = cur_q;
        hdr_wd     = h_q;
        hdr_wd.nxt = x_q;
        state_d    = sub_ret_q;
      end

      S_REM: begin
        hdr_ra  = x_q;
        state_d = S_REM_CHK;
      end

      S_REM_CHK: begin
        h_d = hdr_rd_q;
        if (head_q == {1'b0, x_q} + 13'd1) begin
          head_d  = (hdr_rd_q.nxt != '0) ? {1'b0, hdr_rd_q.nxt} + 13'd1 : '0;
          state_d = S_REM_NX;
        end else begin
          hdr_ra  = hdr_rd_q.prev;
          state_d = S_REM_PV_WR;
        end
      end

      S_REM_PV_WR: begin
        hw.nxt  = h_q.nxt;
        hdr_we  = 1'b1;
        hdr_wa  = h_q.prev;
        hdr_wd  = hw;
        state_d = S_REM_NX;
      end

      S_REM_NX: begin
        if (h_q.nxt != '0) begin
          hdr_ra  = h_q.nxt;
          state_d = S_REM_NX_WR;
        end else begin
          state_d = S_REM_X_WR;
        end
      end

      S_REM_NX_WR: begin
        hw.prev = h_q.prev;
        hdr_we  = 1'b1;
        hdr_wa  = h_q.nxt;
        hdr_wd  = hw;
        state_d = S_REM_X_WR;
      end

      S_REM_X_WR: begin
        hdr_we  = 1'b1;
        hdr_wa  = x_q;
        hdr_wd  = '{is_free: h_q.is_free, prev: '0, nxt: '0, size: h_q.size};
        state_d = sub_ret_q;
      end

      S_MG_RD2: begin
        hdr_ra  = m2_q;
        state_d = S_MG_RD1;
      end

      S_MG_RD1: begin
        msz_d   = hdr_rd_q.size;
        hdr_ra  = m1_q;
        state_d = S_MG_WR1;
      end

      S_MG_WR1: begin
        hw.size   = hdr_rd_q.size + msz_q + MetaG[GranW-1:0];
        hdr_we    = 1'b1;
        hdr_wa    = m1_q;
        hdr_wd    = hw;
        msz_d     = hw.size;
        x_d       = m2_q;
        sub_ret_d = S_MG_TAG;
        state_d   = S_REM;
      end

      S_MG_TAG: begin
        tag_we  = 1'b1;
        tag_wa  = tag_idx({2'b00, m1_q} + {1'b0, HdrG} + {2'b00, msz_q});
        tag_wd  = msz_q;
        state_d = mrg_ret_q;
      end

      S_FR_NX_RD: begin
        hdr_ra  = b_q;
        state_d = S_FR_NX_CHK;
      end

      S_FR_NX_CHK: begin
        if (nx14 < {1'b0, end_g_q}) begin
          hdr_ra  = nx14[GranW-1:0];
          m2_d    = nx14[GranW-1:0];
          state_d = S_FR_NX_CHK2;
        end else begin
          state_d = S_FR_PV;
        end
      end

      S_FR_NX_CHK2: begin
        if (hdr_rd_q.is_free) begin
          m1_d      = b_q;
          mrg_ret_d = S_FR_PV;
          state_d   = S_MG_RD2;
        end else begin
          state_d = S_FR_PV;
        end
      end

      S_FR_PV: begin
        if ({1'b0, b_q} >= MetaG) begin
          tag_ra  = b_q - TagG[GranW-1:0];
          state_d = S_FR_PV_CHK;
        end else begin
          state_d = S_DONE;
        end
      end

      S_FR_PV_CHK: begin
        if (tag_rd_q <= b_q - MetaG[GranW-1:0]) begin
          hdr_ra  = b_q - MetaG[GranW-1:0] - tag_rd_q;
          m1_d    = b_q - MetaG[GranW-1:0] - tag_rd_q;
          state_d = S_FR_PV_CHK2;
        end else begin
          state_d = S_DONE;
        end
      end

      S_FR_PV_CHK2: begin
        if (hdr_rd_q.is_free) begin
          m2_d      = b_q;
          mrg_ret_d = S_DONE;
          state_d   = S_MG_RD2;
        end else begin
          state_d = S_DONE;
        end
      end

      S_FIT_RD: begin
        hdr_ra  = cur_q;
        state_d = S_FIT_CHK;
      end

      S_FIT_CHK: begin
        if ({1'b0, hdr_rd_q.size} >= user_g_q) begin
          b_d       = cur_q;
          fsz_d     = hdr_rd_q.size;
          x_d       = cur_q;
          sub_ret_d = S_AL_SPLIT;
          state_d   = S_REM;
        end else if (hdr_rd_q.nxt == '0) begin
          state_d = S_GROW;
        end else begin
          cur_d   = hdr_rd_q.nxt;
          state_d = S_FIT_RD;
        end
      end

      S_AL_SPLIT: begin
        res_d.result_address = user_addr(b_q);
        hdr_we = 1'b1;
        hdr_wa = b_q;
        if (left > SplitMin) begin
          hdr_wd  = '{is_free: 1'b0, prev: '0, nxt: '0, size: user_g_q[GranW-1:0]};
          tag_we  = 1'b1;
          tag_wa  = tag_idx({2'b00, b_q} + {1'b0, HdrG} + {1'b0, user_g_q});
          tag_wd  = user_g_q[GranW-1:0];
          state_d = S_AL_SPLIT2;
        end else begin
          hdr_wd  = '{is_free: 1'b0, prev: '0, nxt: '0, size: fsz_q};
          state_d = S_DONE;
        end
      end

      S_AL_SPLIT2: begin
        tag_we    = 1'b1;
        tag_wa    = tag_idx({2'b00, spos} + {1'b0, HdrG} + {2'b00, lsz});
        tag_wd    = lsz;
        x_d       = spos;
        xsize_d   = lsz;
        sub_ret_d = S_DONE;
        state_d   = S_INS;
      end

      S_GROW: begin
        if ({sum14, 4'b0000} >= {1'b0, heap_q}) begin
          if ({heap_q, 1'b0} > HeapMaxBytes) begin
            res_d.status = ST_OOM;
            state_d      = S_DONE;
          end else begin
            heap_d = {heap_q[HeapW-2:0], 1'b0};
          end
        end else begin
          hdr_we  = 1'b1;
          hdr_wa  = end_g_q[GranW-1:0];
          hdr_wd  = '{is_free: 1'b0, prev: '0, nxt: '0, size: user_g_q[GranW-1:0]};
          tag_we  = 1'b1;
          tag_wa  = tag_idx({1'b0, end_g_q} + {1'b0, HdrG} + {1'b0, user_g_q});
          tag_wd  = user_g_q[GranW-1:0];
          res_d.result_address = user_addr(end_g_q[GranW-1:0]);
          end_g_d = sum14[UserGW-1:0];
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      end_g_q     <= '0;
      heap_q      <= '0;
      started_q   <= 1'b0;
      init_q      <= 17'd4096;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      end_g_q     <= end_g_d;
      heap_q      <= heap_d;
      started_q   <= started_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        init_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sub_ret_q <= sub_ret_d;
    mrg_ret_q <= mrg_ret_d;
    user_g_q  <= user_g_d;
    b_q       <= b_d;
    cur_q     <= cur_d;
    x_q       <= x_d;
    xsize_q   <= xsize_d;
    m1_q      <= m1_d;
    m2_q      <= m2_d;
    msz_q     <= msz_d;
    fsz_q     <= fsz_d;
    g_q       <= g_d;
    h_q       <= h_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

endmodule
